// ===== design/atilt_pkg.sv =====
// Shared types, constants and the arctangent table function for the tilt angle core.
package atilt_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 20;
    localparam int FRAC_BITS         = 27;
    localparam int GAIN_W            = 31;
    localparam int GAIN_FRAC         = 30;
    localparam int ANG_W             = 58;
    localparam int R_W               = 64;
    localparam int Q_BITS            = 7;
    localparam int DEG_W             = 8;
    localparam int DEG_RIGHT         = 90;
    localparam int DEG_PER_HALF_TURN = 180;

    localparam logic [GAIN_W-1:0] GAIN_Q30    = 31'd1768195363;
    localparam logic [63:0]       PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [R_W-1:0]    PI_Q54      = PI_Q60 >> 6;
    localparam logic [R_W-1:0]    HALF_PI_Q54 = PI_Q54 >> 1;

    typedef struct packed {
        logic neg;
        logic force_zero;
        logic force_ninety;
    } atilt_flags_t;

    // Elaboration-time arctangent of 2^-idx in Q54 radians. The Taylor terms are
    // truncated one by one, and each term comes from a shift-subtract division.
    function automatic logic [ANG_W-1:0] atan_q54(input int idx);
        logic [63:0] acc;
        logic [63:0] num;
        logic [63:0] term;
        logic [63:0] rem;
        logic [63:0] odd_v;
        int          k;
        int          drop;
        int          b;
        if (idx == 0) begin
            return ANG_W'(PI_Q60 >> 8);
        end
        acc  = '0;
        k    = 0;
        drop = idx;
        while (drop <= 54) begin
            num   = 64'd1 << (54 - drop);
            odd_v = 64'(2 * k + 1);
            term  = '0;
            rem   = '0;
            for (b = 63; b >= 0; b--) begin
                rem = {rem[62:0], num[b]};
                if (rem >= odd_v) begin
                    rem     = rem - odd_v;
                    term[b] = 1'b1;
                end
            end
            acc  = k[0] ? acc - term : acc + term;
            k    = k + 1;
            drop = idx * (2 * k + 1);
        end
        return acc[ANG_W-1:0];
    endfunction

endpackage

// ===== design/accel_tilt_angle_core.sv =====
// Top level of the accelerometer tilt angle core: two CORDIC chains and a degree divider.
// Throughput is one beat per clock; a new sample is taken in every cycle while the output side flows.
// The pipeline runs through the input and multiply stages,
// the two unrolled CORDIC chains, the scaling stage, seven divider steps and the output register.
// A two-entry output buffer keeps s_axis_tready registered; it drops only when both entries hold.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
module accel_tilt_angle_core
    import atilt_pkg::*;
#(
    parameter int  SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int  CORDIC_STAGES = CORDIC_STAGES_DEF,
    localparam int S_TDATA_W     = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // accel_x, accel_y, accel_z from the lowest bit up, zero padded to whole bytes.
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tilt_degrees.
    output logic [DEG_W-1:0]     m_axis_tdata
);

    localparam int MAG_W    = SAMPLE_BITS + 1;
    localparam int CW       = SAMPLE_BITS + FRAC_BITS + 4;
    localparam int PROD_W   = MAG_W + GAIN_W;
    localparam int XS_SHIFT = GAIN_FRAC - FRAC_BITS;
    localparam int N        = CORDIC_STAGES;

    logic run;

    // Input stage: magnitudes and special-case flags.
    logic signed [SAMPLE_BITS-1:0] x_in;
    logic signed [SAMPLE_BITS-1:0] y_in;
    logic signed [SAMPLE_BITS-1:0] z_in;
    logic signed [MAG_W-1:0]       x_ext;
    logic signed [MAG_W-1:0]       y_ext;
    logic signed [MAG_W-1:0]       z_ext;
    logic [MAG_W-1:0]              ax_next;
    logic [MAG_W-1:0]              ay_next;
    logic [MAG_W-1:0]              az_next;
    atilt_flags_t                  f_flags_next;
    logic                          f_valid_reg;
    logic [MAG_W-1:0]              ax_reg;
    logic [MAG_W-1:0]              ay_reg;
    logic [MAG_W-1:0]              az_reg;
    atilt_flags_t                  f_flags_reg;

    assign x_in  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign y_in  = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign z_in  = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    assign x_ext = MAG_W'(x_in);
    assign y_ext = MAG_W'(y_in);
    assign z_ext = MAG_W'(z_in);

    always_comb begin
        ax_next = x_ext[MAG_W-1] ? MAG_W'(-x_ext) : MAG_W'(x_ext);
        ay_next = y_ext[MAG_W-1] ? MAG_W'(-y_ext) : MAG_W'(y_ext);
        az_next = z_ext[MAG_W-1] ? MAG_W'(-z_ext) : MAG_W'(z_ext);
        f_flags_next.neg          = x_in[SAMPLE_BITS-1];
        f_flags_next.force_zero   = (x_in == '0);
        f_flags_next.force_ninety = (y_in == '0) && (z_in == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (run) begin
            f_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (run) begin
            ax_reg      <= ax_next;
            ay_reg      <= ay_next;
            az_reg      <= az_next;
            f_flags_reg <= f_flags_next;
        end
    end

    // Multiply stage: fixed-point alignment and gain scaling of x.
    logic [PROD_W-1:0]    prod;
    logic                 mul_valid_reg;
    logic signed [CW-1:0] mul_a_reg;
    logic signed [CW-1:0] mul_b_reg;
    logic signed [CW-1:0] mul_xs_reg;
    atilt_flags_t         mul_flags_reg;

    assign prod = PROD_W'(ax_reg) * PROD_W'(GAIN_Q30);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (run) begin
            mul_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (run) begin
            mul_a_reg     <= $signed(CW'({ay_reg, {FRAC_BITS{1'b0}}}));
            mul_b_reg     <= $signed(CW'({az_reg, {FRAC_BITS{1'b0}}}));
            mul_xs_reg    <= $signed(CW'(prod >> XS_SHIFT));
            mul_flags_reg <= f_flags_reg;
        end
    end

    // Magnitude chain.
    logic                 c1_v  [0:N];
    logic signed [CW-1:0] c1_a  [0:N];
    logic signed [CW-1:0] c1_b  [0:N-1];
    logic signed [CW-1:0] c1_xs [0:N];
    atilt_flags_t         c1_f  [0:N];

    assign c1_v[0]  = mul_valid_reg;
    assign c1_a[0]  = mul_a_reg;
    assign c1_b[0]  = mul_b_reg;
    assign c1_xs[0] = mul_xs_reg;
    assign c1_f[0]  = mul_flags_reg;

    for (genvar i = 0; i < N; i++) begin : g_mag
        if (i < N - 1) begin : g_mid
            atilt_mag_cell #(.W(CW), .SHIFT(i)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (run),
                .valid_in  (c1_v[i]),
                .a_in      (c1_a[i]),
                .b_in      (c1_b[i]),
                .xs_in     (c1_xs[i]),
                .flags_in  (c1_f[i]),
                .valid_out (c1_v[i+1]),
                .a_out     (c1_a[i+1]),
                .b_out     (c1_b[i+1]),
                .xs_out    (c1_xs[i+1]),
                .flags_out (c1_f[i+1])
            );
        end else begin : g_last
            atilt_mag_cell #(.W(CW), .SHIFT(i)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (run),
                .valid_in  (c1_v[i]),
                .a_in      (c1_a[i]),
                .b_in      (c1_b[i]),
                .xs_in     (c1_xs[i]),
                .flags_in  (c1_f[i]),
                .valid_out (c1_v[i+1]),
                .a_out     (c1_a[i+1]),
                .b_out     (),
                .xs_out    (c1_xs[i+1]),
                .flags_out (c1_f[i+1])
            );
        end
    end

    // Angle chain.
    logic                    c2_v [0:N];
    logic signed [CW-1:0]    c2_a [0:N-1];
    logic signed [CW-1:0]    c2_b [0:N-1];
    logic signed [ANG_W-1:0] c2_z [0:N];
    atilt_flags_t            c2_f [0:N];

    assign c2_v[0] = c1_v[N];
    assign c2_a[0] = c1_a[N];
    assign c2_b[0] = c1_xs[N];
    assign c2_z[0] = '0;
    assign c2_f[0] = c1_f[N];

    for (genvar i = 0; i < N; i++) begin : g_ang
        if (i < N - 1) begin : g_mid
            atilt_angle_cell #(.W(CW), .SHIFT(i), .ATAN(atan_q54(i))) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (run),
                .valid_in  (c2_v[i]),
                .a_in      (c2_a[i]),
                .b_in      (c2_b[i]),
                .z_in      (c2_z[i]),
                .flags_in  (c2_f[i]),
                .valid_out (c2_v[i+1]),
                .a_out     (c2_a[i+1]),
                .b_out     (c2_b[i+1]),
                .z_out     (c2_z[i+1]),
                .flags_out (c2_f[i+1])
            );
        end else begin : g_last
            atilt_angle_cell #(.W(CW), .SHIFT(i), .ATAN(atan_q54(i))) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (run),
                .valid_in  (c2_v[i]),
                .a_in      (c2_a[i]),
                .b_in      (c2_b[i]),
                .z_in      (c2_z[i]),
                .flags_in  (c2_f[i]),
                .valid_out (c2_v[i+1]),
                .a_out     (),
                .b_out     (),
                .z_out     (c2_z[i+1]),
                .flags_out (c2_f[i+1])
            );
        end
    end

    // Scaling stage: clamp to the first quadrant and scale the angle by 180.
    logic signed [ANG_W-1:0] ang;
    logic                    ang_low;
    logic                    ang_high;
    atilt_flags_t            p_flags_next;
    logic                    p_valid_reg;
    logic [R_W-1:0]          p_r_reg;
    atilt_flags_t            p_flags_reg;

    assign ang      = c2_z[N];
    assign ang_low  = ang[ANG_W-1] || (ang == '0);
    assign ang_high = !ang[ANG_W-1] && ($unsigned(ang) >= ANG_W'(HALF_PI_Q54));

    always_comb begin
        p_flags_next.neg          = c2_f[N].neg;
        p_flags_next.force_zero   = c2_f[N].force_zero
                                    || (!c2_f[N].force_ninety && ang_low);
        p_flags_next.force_ninety = !c2_f[N].force_zero
                                    && (c2_f[N].force_ninety || ang_high);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (run) begin
            p_valid_reg <= c2_v[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (run) begin
            p_r_reg     <= R_W'($unsigned(ang)) * R_W'(DEG_PER_HALF_TURN);
            p_flags_reg <= p_flags_next;
        end
    end

    // Degree divider, most significant quotient bit first.
    logic              d_v [0:Q_BITS];
    logic [R_W-1:0]    d_r [0:Q_BITS-1];
    logic [Q_BITS-1:0] d_q [0:Q_BITS];
    atilt_flags_t      d_f [0:Q_BITS];

    assign d_v[0] = p_valid_reg;
    assign d_r[0] = p_r_reg;
    assign d_q[0] = '0;
    assign d_f[0] = p_flags_reg;

    for (genvar i = 0; i < Q_BITS; i++) begin : g_div
        if (i < Q_BITS - 1) begin : g_mid
            atilt_div_cell #(.BIT(Q_BITS - 1 - i)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (run),
                .valid_in  (d_v[i]),
                .r_in      (d_r[i]),
                .q_in      (d_q[i]),
                .flags_in  (d_f[i]),
                .valid_out (d_v[i+1]),
                .r_out     (d_r[i+1]),
                .q_out     (d_q[i+1]),
                .flags_out (d_f[i+1])
            );
        end else begin : g_last
            atilt_div_cell #(.BIT(Q_BITS - 1 - i)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (run),
                .valid_in  (d_v[i]),
                .r_in      (d_r[i]),
                .q_in      (d_q[i]),
                .flags_in  (d_f[i]),
                .valid_out (d_v[i+1]),
                .r_out     (),
                .q_out     (d_q[i+1]),
                .flags_out (d_f[i+1])
            );
        end
    end

    // Final sign and output buffering.
    logic [DEG_W-1:0] deg_mag;
    logic [DEG_W-1:0] tilt_degrees;
    logic             push;
    logic             take;
    logic             out_valid_reg;
    logic [DEG_W-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [DEG_W-1:0] skid_data_reg;

    always_comb begin
        if (d_f[Q_BITS].force_zero) begin
            deg_mag = '0;
        end else if (d_f[Q_BITS].force_ninety) begin
            deg_mag = DEG_W'(DEG_RIGHT);
        end else begin
            deg_mag = DEG_W'(d_q[Q_BITS]);
        end
        tilt_degrees = d_f[Q_BITS].neg ? DEG_W'(-deg_mag) : deg_mag;
    end

    assign run  = !skid_valid_reg;
    assign push = run && d_v[Q_BITS];
    assign take = out_valid_reg && m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!skid_valid_reg) begin
            if (push) begin
                if (!out_valid_reg || take) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (take) begin
                out_valid_reg <= 1'b0;
            end
        end else if (take) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg) begin
            if (push && (!out_valid_reg || take)) begin
                out_data_reg <= tilt_degrees;
            end
            if (push && out_valid_reg && !take) begin
                skid_data_reg <= tilt_degrees;
            end
        end else if (take) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign s_axis_tready = run;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTH
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Buffered beat held while the output register is empty.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ($signed(out_data_reg) <= $signed(DEG_W'(DEG_RIGHT))
                           && $signed(out_data_reg) >= -$signed(DEG_W'(DEG_RIGHT))))
        else $error("Tilt angle outside the range of a quarter turn.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("Buffer filled although the output beat was taken or absent.");
`endif

endmodule

// ===== design/atilt_mag_cell.sv =====
// One vectoring CORDIC stage of the magnitude chain, carrying the scaled x value along.
module atilt_mag_cell
    import atilt_pkg::*;
#(
    parameter int W     = 47,
    parameter int SHIFT = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                valid_in,
    input  logic signed [W-1:0] a_in,
    input  logic signed [W-1:0] b_in,
    input  logic signed [W-1:0] xs_in,
    input  atilt_flags_t        flags_in,
    output logic                valid_out,
    output logic signed [W-1:0] a_out,
    output logic signed [W-1:0] b_out,
    output logic signed [W-1:0] xs_out,
    output atilt_flags_t        flags_out
);

    logic                valid_reg;
    logic signed [W-1:0] a_reg;
    logic signed [W-1:0] a_next;
    logic signed [W-1:0] b_reg;
    logic signed [W-1:0] b_next;
    logic signed [W-1:0] xs_reg;
    atilt_flags_t        flags_reg;

    always_comb begin
        if (!b_in[W-1]) begin
            a_next = a_in + (b_in >>> SHIFT);
            b_next = b_in - (a_in >>> SHIFT);
        end else begin
            a_next = a_in - (b_in >>> SHIFT);
            b_next = b_in + (a_in >>> SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            xs_reg    <= xs_in;
            flags_reg <= flags_in;
        end
    end

    assign valid_out = valid_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;
    assign xs_out    = xs_reg;
    assign flags_out = flags_reg;

endmodule

// ===== design/atilt_angle_cell.sv =====
// One vectoring CORDIC stage of the angle chain with its angle accumulator.
module atilt_angle_cell
    import atilt_pkg::*;
#(
    parameter int               W     = 47,
    parameter int               SHIFT = 0,
    parameter logic [ANG_W-1:0] ATAN  = '0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    valid_in,
    input  logic signed [W-1:0]     a_in,
    input  logic signed [W-1:0]     b_in,
    input  logic signed [ANG_W-1:0] z_in,
    input  atilt_flags_t            flags_in,
    output logic                    valid_out,
    output logic signed [W-1:0]     a_out,
    output logic signed [W-1:0]     b_out,
    output logic signed [ANG_W-1:0] z_out,
    output atilt_flags_t            flags_out
);

    logic                    valid_reg;
    logic signed [W-1:0]     a_reg;
    logic signed [W-1:0]     a_next;
    logic signed [W-1:0]     b_reg;
    logic signed [W-1:0]     b_next;
    logic signed [ANG_W-1:0] z_reg;
    logic signed [ANG_W-1:0] z_next;
    atilt_flags_t            flags_reg;

    always_comb begin
        if (!b_in[W-1]) begin
            a_next = a_in + (b_in >>> SHIFT);
            b_next = b_in - (a_in >>> SHIFT);
            z_next = z_in + $signed(ATAN);
        end else begin
            a_next = a_in - (b_in >>> SHIFT);
            b_next = b_in + (a_in >>> SHIFT);
            z_next = z_in - $signed(ATAN);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            z_reg     <= z_next;
            flags_reg <= flags_in;
        end
    end

    assign valid_out = valid_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;
    assign z_out     = z_reg;
    assign flags_out = flags_reg;

endmodule

// ===== design/atilt_div_cell.sv =====
// One restoring division step that turns the scaled angle into one quotient bit of degrees.
module atilt_div_cell
    import atilt_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              valid_in,
    input  logic [R_W-1:0]    r_in,
    input  logic [Q_BITS-1:0] q_in,
    input  atilt_flags_t      flags_in,
    output logic              valid_out,
    output logic [R_W-1:0]    r_out,
    output logic [Q_BITS-1:0] q_out,
    output atilt_flags_t      flags_out
);

    localparam logic [R_W-1:0] DIV_STEP = PI_Q54 << BIT;

    logic              valid_reg;
    logic [R_W-1:0]    r_reg;
    logic [R_W-1:0]    r_next;
    logic [Q_BITS-1:0] q_reg;
    logic [Q_BITS-1:0] q_next;
    atilt_flags_t      flags_reg;

    always_comb begin
        if (r_in >= DIV_STEP) begin
            r_next = r_in - DIV_STEP;
            q_next = q_in | (Q_BITS'(1) << BIT);
        end else begin
            r_next = r_in;
            q_next = q_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg     <= r_next;
            q_reg     <= q_next;
            flags_reg <= flags_in;
        end
    end

    assign valid_out = valid_reg;
    assign r_out     = r_reg;
    assign q_out     = q_reg;
    assign flags_out = flags_reg;

endmodule
